/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Word types, fixed-point constants and hue sector codes.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 16;
  localparam int unsigned FX_W   = 17;
  localparam int unsigned CH_W   = 8;
  localparam int unsigned FRAC_W = 16;

  // 1.0 in 16-bit fraction fixed point
  localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_W;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [FX_W-1:0]  saturation;
    logic [FX_W-1:0]  brightness;
  } hsv_word_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_word_t;

endpackage

/* rtl/hsv2rgb_in_if.sv */
// ----------------------------------------------------------------------------
// HSV word channel
// Valid/ready handshake carrying one HSV color.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();

  logic      valid;
  logic      ready;
  hsv_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/hsv2rgb_out_if.sv */
// ----------------------------------------------------------------------------
// RGB word channel
// Valid/ready handshake carrying one 8-bit RGB color.
// ----------------------------------------------------------------------------
interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();

  logic      valid;
  logic      ready;
  rgb_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Takes one HSV word per clock, unless a stalled output has filled all five
// register stages, and returns one 8-bit RGB word for each. Each stage has
// its own valid bit and is refilled as soon as it empties, so a stalled
// output only holds back the words behind it and bubbles close up.
// Stage one splits the hue into sector and fraction, stage two forms the
// saturation-times-fraction products, stage three the p, q and t factors,
// stage four multiplies them by brightness (17 x 33 bit, the longest path),
// and stage five scales by 255, clamps and routes the channels.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsv2rgb_in_if.sink    hsv_i,
  hsv2rgb_out_if.source rgb_o
);

  localparam int unsigned PW = 2 * FX_W - 1;   // factor width, holds 1.0 over 2^32
  localparam int unsigned MW = FX_W + PW;      // brightness times factor
  localparam int unsigned SW = MW + CH_W;      // times 255

  function automatic logic [CH_W-1:0] to_channel(input logic [MW-1:0] m);
    logic [SW-1:0]   s;
    logic [SW-49:0]  top;
    s   = {m, CH_W'(0)} - {CH_W'(0), m};
    top = s[SW-1:48];
    return (top > (SW-48)'(255)) ? CH_W'(255) : top[CH_W-1:0];
  endfunction

  // per-stage valid and ready
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_q || rgb_o.ready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign hsv_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= hsv_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // stage 1: hue times six -> sector and fraction
  logic [HUE_W+2:0]  hh;
  logic [2:0]        sec1_d, sec1_q;
  logic [FRAC_W-1:0] f1_d, f1_q;
  logic [FX_W-1:0]   sat1_q, val1_q;

  assign hh     = ({3'b000, hsv_i.data.hue} << 2) + ({3'b000, hsv_i.data.hue} << 1);
  assign sec1_d = hh[HUE_W+2:HUE_W];
  assign f1_d   = hh[FRAC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (rdy1 && hsv_i.valid) begin
      sec1_q <= sec1_d;
      f1_q   <= f1_d;
      sat1_q <= hsv_i.data.saturation;
      val1_q <= hsv_i.data.brightness;
    end
  end

  // stage 2: s*f and s*(1-f)
  logic [FX_W-1:0]          inv_f;
  logic [FX_W+FRAC_W-1:0]   sf2_d, sf2_q;
  logic [2*FX_W-1:0]        sif2_d, sif2_q;
  logic [2:0]               sec2_q;
  logic [FX_W-1:0]          sat2_q, val2_q;

  assign inv_f  = ONE_FX - {1'b0, f1_q};
  assign sf2_d  = sat1_q * f1_q;
  assign sif2_d = sat1_q * inv_f;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sf2_q  <= sf2_d;
      sif2_q <= sif2_d;
      sec2_q <= sec1_q;
      sat2_q <= sat1_q;
      val2_q <= val1_q;
    end
  end

  // stage 3: p, q, t factors over 2^32, zero where not positive
  localparam logic [2*FX_W:0] ONE2 = (2*FX_W+1)'(1) << (2*FRAC_W);

  logic [FX_W:0]     pd;
  logic [2*FX_W:0]   qd, td;
  logic [PW-1:0]     xp3_d, xq3_d, xt3_d;
  logic [PW-1:0]     xp3_q, xq3_q, xt3_q;
  logic [2:0]        sec3_q;
  logic [FX_W-1:0]   val3_q;

  assign pd = {1'b0, ONE_FX} - {1'b0, sat2_q};
  assign qd = ONE2 - {2'b00, sf2_q};
  assign td = ONE2 - {1'b0, sif2_q};

  assign xp3_d = (!pd[FX_W] && pd != '0) ? {pd[FX_W-1:0], FRAC_W'(0)} : '0;
  assign xq3_d = (!qd[2*FX_W] && qd != '0) ? qd[PW-1:0] : '0;
  assign xt3_d = (!td[2*FX_W] && td != '0) ? td[PW-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      xp3_q  <= xp3_d;
      xq3_q  <= xq3_d;
      xt3_q  <= xt3_d;
      sec3_q <= sec2_q;
      val3_q <= val2_q;
    end
  end

  // stage 4: brightness times factors, numerators over 2^48
  logic [MW-1:0]   mp4_q, mq4_q, mt4_q;
  logic [2:0]      sec4_q;
  logic [FX_W-1:0] val4_q;

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      mp4_q  <= val3_q * xp3_q;
      mq4_q  <= val3_q * xq3_q;
      mt4_q  <= val3_q * xt3_q;
      sec4_q <= sec3_q;
      val4_q <= val3_q;
    end
  end

  // stage 5: scale, clamp, sector mux
  logic [CH_W-1:0] cv, cp, cq, ct;
  rgb_word_t       rgb5_d, rgb5_q;

  assign cv = to_channel(MW'({val4_q, (2*FRAC_W)'(0)}));
  assign cp = to_channel(mp4_q);
  assign cq = to_channel(mq4_q);
  assign ct = to_channel(mt4_q);

  always_comb begin
    unique case (sector_e'(sec4_q))
      SEC_RY:  rgb5_d = '{red: cv, green: ct, blue: cp};
      SEC_YG:  rgb5_d = '{red: cq, green: cv, blue: cp};
      SEC_GC:  rgb5_d = '{red: cp, green: cv, blue: ct};
      SEC_CB:  rgb5_d = '{red: cp, green: cq, blue: cv};
      SEC_BM:  rgb5_d = '{red: ct, green: cp, blue: cv};
      default: rgb5_d = '{red: cv, green: cp, blue: cq};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      rgb5_q <= rgb5_d;
    end
  end

  assign rgb_o.valid = v5_q;
  assign rgb_o.data  = rgb5_q;

endmodule

/* bench/hsv2rgb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB scoreboard
// Watches both channels of the converter. Every accepted HSV word is turned
// into its exact RGB word and queued. Every accepted RGB word is compared
// channel by channel against the oldest queued one.
// ----------------------------------------------------------------------------
module hsv2rgb_checker import hsv2rgb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  hsv2rgb_in_if  hsv_i,
  hsv2rgb_out_if rgb_i,
  output int     fail_count_o,
  output int     pending_o,
  output int     checked_o
);

  localparam int MAX_REPORTS = 40;
  localparam int TERM_SHIFT  = 3 * FRAC_W;

  rgb_word_t rgb_expected[$];
  int        fail_cnt;
  int        checked_cnt;

  // floor(num * 255 / 2^48), clamped to the 8-bit channel range
  function automatic logic [CH_W-1:0] scale_channel(input longint num);
    longint scaled;
    if (num <= 0) return '0;
    scaled = (num * 255) >>> TERM_SHIFT;
    return (scaled > 255) ? 8'd255 : scaled[CH_W-1:0];
  endfunction

  function automatic rgb_word_t predict_rgb(input hsv_word_t w);
    longint          one_fx;
    longint          hh;
    longint          frac;
    longint          sat;
    longint          val;
    logic [CH_W-1:0] cv, cp, cq, ct;
    sector_e         sec;
    rgb_word_t       rgb;
    one_fx = longint'(ONE_FX);
    hh     = longint'(w.hue) * 6;
    sec    = sector_e'(hh[FRAC_W+2:FRAC_W]);
    frac   = hh & (one_fx - 1);
    sat    = longint'(w.saturation);
    val    = longint'(w.brightness);
    cv = scale_channel(val * one_fx * one_fx);
    cp = scale_channel(val * (one_fx - sat) * one_fx);
    cq = scale_channel(val * (one_fx * one_fx - sat * frac));
    ct = scale_channel(val * (one_fx * one_fx - sat * (one_fx - frac)));
    case (sec)
      SEC_RY:  rgb = '{red: cv, green: ct, blue: cp};
      SEC_YG:  rgb = '{red: cq, green: cv, blue: cp};
      SEC_GC:  rgb = '{red: cp, green: cv, blue: ct};
      SEC_CB:  rgb = '{red: cp, green: cq, blue: cv};
      SEC_BM:  rgb = '{red: ct, green: cp, blue: cv};
      default: rgb = '{red: cv, green: cp, blue: cq};
    endcase
    return rgb;
  endfunction

  task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_word_t want;
    if (!rst_ni) begin
      rgb_expected.delete();
      fail_cnt    = 0;
      checked_cnt = 0;
    end else begin
      if (hsv_i.valid && hsv_i.ready)
        rgb_expected.push_back(predict_rgb(hsv_i.data));
      if (rgb_i.valid && rgb_i.ready) begin
        if (rgb_expected.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected RGB word, expected none, actual %h", $time,
                     rgb_i.data);
        end else begin
          want = rgb_expected.pop_front();
          checked_cnt++;
          check_channel("red", want.red, rgb_i.data.red);
          check_channel("green", want.green, rgb_i.data.green);
          check_channel("blue", want.blue, rgb_i.data.blue);
        end
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= rgb_expected.size();
    checked_o    <= checked_cnt;
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives corner colors and then about 900 random HSV words in bursts, with a
// receiver that stalls in changing patterns. Checking is done by the
// scoreboard instance; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_WORDS = 900;
  localparam int DRAIN_EVERY  = 300;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_FX       = 131071;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCK
  } rx_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hsv2rgb_in_if  hsv_if ();
  hsv2rgb_out_if rgb_if ();

  int       fail_count;
  int       pending;
  int       checked;
  int       cycles;
  int       burst_left;
  int       words_sent;
  int       gray_sent;
  int       over_sent;
  rx_mode_e rx_mode = RX_FREE;
  logic [7:0] rx_cnt = '0;

  always #2 clk = ~clk;

  hsv_to_rgb_converter dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .hsv_i (hsv_if.sink),
    .rgb_o (rgb_if.source)
  );

  hsv2rgb_checker scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .hsv_i       (hsv_if),
    .rgb_i       (rgb_if),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d RGB words outstanding", $time, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure, pattern switches each time the 8-bit counter wraps
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 1'b1;
    if (rx_cnt == '0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:   rgb_if.ready <= 1'b1;
      RX_COIN:   rgb_if.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rgb_if.ready <= ($urandom_range(0, 3) == 0);
      default:   rgb_if.ready <= ~rx_cnt[4];
    endcase
  end

  function automatic hsv_word_t make_hsv(input int h, input int s, input int v);
    hsv_word_t w;
    w.hue        = h[HUE_W-1:0];
    w.saturation = s[FX_W-1:0];
    w.brightness = v[FX_W-1:0];
    return w;
  endfunction

  function automatic hsv_word_t random_hsv();
    int pick;
    int k;
    int h;
    pick = $urandom_range(0, 99);
    h    = $urandom_range(0, 65535);
    if (pick < 55)
      return make_hsv(h, $urandom_range(0, 65536), $urandom_range(0, 65536));
    if (pick < 70)
      return make_hsv(h, $urandom_range(0, MAX_FX), $urandom_range(0, MAX_FX));
    if (pick < 80)
      return make_hsv(h, 0, $urandom_range(0, MAX_FX));
    if (pick < 90)
      return make_hsv(h, $urandom_range(0, 1) ? 65536 : $urandom_range(0, MAX_FX),
                      $urandom_range(0, 1) ? 65536 : $urandom_range(0, MAX_FX));
    // hue close to a sector boundary
    k = $urandom_range(1, 5);
    h = (k * 65536 + 5) / 6 + $urandom_range(0, 4) - 2;
    return make_hsv(h, $urandom_range(0, 65536), $urandom_range(0, 65536));
  endfunction

  task automatic send_hsv(input hsv_word_t w);
    int gap;
    hsv_if.valid <= 1'b1;
    hsv_if.data  <= w;
    do @(posedge clk); while (!hsv_if.ready);
    words_sent++;
    if (w.saturation == '0) gray_sent++;
    if (w.saturation > ONE_FX || w.brightness > ONE_FX) over_sent++;
    if (burst_left == 0) begin
      hsv_if.valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    hsv_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    hsv_if.valid <= 1'b0;
    hsv_if.data  <= '0;
    words_sent   = 0;
    gray_sent    = 0;
    over_sent    = 0;
    burst_left   = $urandom_range(0, 12);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gray, black and white
    send_hsv(make_hsv(0, 0, 65536));
    send_hsv(make_hsv(12345, 0, 32768));
    send_hsv(make_hsv(0, 0, 0));
    send_hsv(make_hsv(54613, 0, MAX_FX));
    // middle of every sector, fully saturated
    send_hsv(make_hsv(5461, 65536, 65536));
    send_hsv(make_hsv(16384, 65536, 65536));
    send_hsv(make_hsv(27307, 65536, 65536));
    send_hsv(make_hsv(38229, 65536, 65536));
    send_hsv(make_hsv(49152, 65536, 65536));
    send_hsv(make_hsv(60075, 65536, 65536));
    // sector edges and hue extremes
    send_hsv(make_hsv(0, 65536, 65536));
    send_hsv(make_hsv(10922, 65536, 65536));
    send_hsv(make_hsv(10923, 65536, 65536));
    send_hsv(make_hsv(65535, 65536, 65536));
    // saturation above one drives terms negative, brightness above one clamps
    send_hsv(make_hsv(21845, MAX_FX, 65536));
    send_hsv(make_hsv(43690, 100000, 65536));
    send_hsv(make_hsv(32768, 40000, MAX_FX));
    send_hsv(make_hsv(65535, MAX_FX, MAX_FX));
    send_hsv(make_hsv(1, 1, 1));
    send_hsv(make_hsv(30000, 65535, 65535));
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_hsv(random_hsv());
      if (i % DRAIN_EVERY == DRAIN_EVERY - 1) drain();
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d HSV words (%0d gray, %0d with saturation or brightness above one),",
             words_sent, gray_sent, over_sent);
    $display("checked %0d RGB words under bursty input and varying output stalls.", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_in_if.sv
rtl/hsv2rgb_out_if.sv
rtl/hsv_to_rgb_converter.sv
bench/hsv2rgb_checker.sv
bench/tb_top.sv
